>>> src/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the periodic trigger scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_CONNECT_INTERVAL = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SYNC_INTERVAL    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_READING_PERIOD   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DISPATCH_PERIOD  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RESYNC_PERIOD    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DISPATCH_PHASE   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_RESYNC_PHASE     = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [DataW-1:0] RST_CONNECT_INTERVAL = 32'd5000;
  localparam logic [DataW-1:0] RST_SYNC_INTERVAL    = 32'd10000;
  localparam logic [DataW-1:0] RST_READING_PERIOD   = 32'd60;
  localparam logic [DataW-1:0] RST_DISPATCH_PERIOD  = 32'd300;
  localparam logic [DataW-1:0] RST_RESYNC_PERIOD    = 32'd3600;
  localparam logic [DataW-1:0] RST_DISPATCH_PHASE   = 32'd0;
  localparam logic [DataW-1:0] RST_RESYNC_PHASE     = 32'd0;

  // Which periodic trigger the shared divider is working on.
  localparam logic [1:0] SEL_READING  = 2'd0;
  localparam logic [1:0] SEL_DISPATCH = 2'd1;
  localparam logic [1:0] SEL_RESYNC   = 2'd2;

  typedef struct packed {
    logic             paired;
    logic             time_synced;
    logic [DataW-1:0] millis_now;
    logic [DataW-1:0] unix_now;
  } pts_in_t;

  typedef struct packed {
    logic connect_trigger;
    logic time_sync_trigger;
    logic reading_trigger;
    logic dispatch_trigger;
  } pts_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load_item;
    logic       eval_ms;
    logic       div_start;
    logic       eval_div;
    logic [1:0] div_sel;
    logic       out_load;
  } pts_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic synced_mode;
    logic div_done;
    logic out_free;
  } pts_sts_t;

endpackage

>>> src/pts_div.sv
// ----------------------------------------------------------------------------
// pts_div
// Restoring divider that returns the 32-bit remainder, one quotient bit per
// cycle. A zero divisor leaves the dividend as the remainder.
// ----------------------------------------------------------------------------
module pts_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pts_pkg::DataW-1:0] num,
  input  logic [pts_pkg::DataW-1:0] den,
  output logic                      done,
  output logic [pts_pkg::DataW-1:0] rem
);
  import pts_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic [DataW-1:0] num_r, num_nxt;
  logic [DataW-1:0] den_r, den_nxt;
  logic [DataW-1:0] rem_r, rem_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DataW:0]   trial;

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[DataW-1]};
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The difference is below the divisor, so it fits in 32 bits.
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial[DataW-1:0] - den_r;
      end else begin
        rem_nxt = trial[DataW-1:0];
      end
      num_nxt = {num_r[DataW-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(DataW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> src/pts_dp.sv
// ----------------------------------------------------------------------------
// pts_dp
// Datapath: configuration registers, tick register, last firing times,
// the shared remainder unit and the result register.
// ----------------------------------------------------------------------------
module pts_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pts_pkg::pts_cmd_t           cmd,
  output pts_pkg::pts_sts_t           sts,
  input  pts_pkg::pts_in_t            in_data,
  input  logic                        cfg_valid,
  input  logic [pts_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [pts_pkg::DataW-1:0]   cfg_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pts_pkg::pts_out_t           out_data
);
  import pts_pkg::*;

  logic [DataW-1:0] conn_int_r, sync_int_r;
  logic [DataW-1:0] read_per_r, disp_per_r, resync_per_r;
  logic [DataW-1:0] disp_phase_r, resync_phase_r;

  logic [DataW-1:0] last_conn_r, last_sync_r;
  logic [DataW-1:0] last_read_r, last_disp_r, last_resync_r;

  pts_in_t          item_r;
  pts_out_t         flags_r;
  pts_out_t         out_r;
  logic             out_valid_r;

  logic [DataW-1:0] div_den;
  logic [DataW-1:0] div_rem;
  logic             div_done;
  logic [DataW-1:0] conn_elapsed, sync_elapsed;
  logic [DataW-1:0] target, last_sel;
  logic             hit;

  pts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (item_r.unix_now),
    .den   (div_den),
    .done  (div_done),
    .rem   (div_rem)
  );

  always_comb begin
    case (cmd.div_sel)
      SEL_READING: begin
        div_den  = read_per_r;
        target   = '0;
        last_sel = last_read_r;
      end
      SEL_DISPATCH: begin
        div_den  = disp_per_r;
        target   = disp_phase_r;
        last_sel = last_disp_r;
      end
      default: begin
        div_den  = resync_per_r;
        target   = resync_phase_r;
        last_sel = last_resync_r;
      end
    endcase
  end

  assign conn_elapsed = item_r.millis_now - last_conn_r;
  assign sync_elapsed = item_r.millis_now - last_sync_r;
  assign hit          = (div_rem == target) && (item_r.unix_now != last_sel);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_int_r     <= RST_CONNECT_INTERVAL;
      sync_int_r     <= RST_SYNC_INTERVAL;
      read_per_r     <= RST_READING_PERIOD;
      disp_per_r     <= RST_DISPATCH_PERIOD;
      resync_per_r   <= RST_RESYNC_PERIOD;
      disp_phase_r   <= RST_DISPATCH_PHASE;
      resync_phase_r <= RST_RESYNC_PHASE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CONNECT_INTERVAL: conn_int_r     <= cfg_data;
        REG_SYNC_INTERVAL:    sync_int_r     <= cfg_data;
        REG_READING_PERIOD:   read_per_r     <= cfg_data;
        REG_DISPATCH_PERIOD:  disp_per_r     <= cfg_data;
        REG_RESYNC_PERIOD:    resync_per_r   <= cfg_data;
        REG_DISPATCH_PHASE:   disp_phase_r   <= cfg_data;
        REG_RESYNC_PHASE:     resync_phase_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tick evaluation and firing history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_conn_r   <= '0;
      last_sync_r   <= '0;
      last_read_r   <= '0;
      last_disp_r   <= '0;
      last_resync_r <= '0;
      flags_r       <= '0;
    end else begin
      if (cmd.load_item) begin
        flags_r <= '0;
      end
      if (cmd.eval_ms) begin
        if (!item_r.paired) begin
          if (conn_elapsed > conn_int_r) begin
            last_conn_r             <= item_r.millis_now;
            flags_r.connect_trigger <= 1'b1;
          end
        end else if (sync_elapsed > sync_int_r) begin
          last_sync_r               <= item_r.millis_now;
          flags_r.time_sync_trigger <= 1'b1;
        end
      end
      if (cmd.eval_div && hit) begin
        case (cmd.div_sel)
          SEL_READING: begin
            last_read_r             <= item_r.unix_now;
            flags_r.reading_trigger <= 1'b1;
          end
          SEL_DISPATCH: begin
            last_disp_r              <= item_r.unix_now;
            flags_r.dispatch_trigger <= 1'b1;
          end
          default: begin
            last_resync_r             <= item_r.unix_now;
            flags_r.time_sync_trigger <= 1'b1;
          end
        endcase
      end
    end
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  // Result register; a new result may load in the cycle the old one transfers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_r <= flags_r;
    end
  end

  assign sts.synced_mode = item_r.paired && item_r.time_synced;
  assign sts.div_done    = div_done;
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> src/pts_ctrl.sv
// ----------------------------------------------------------------------------
// pts_ctrl
// Controller: takes a tick, picks the mode and steps the shared divider
// through the reading, dispatch and resync periods.
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pts_pkg::pts_sts_t sts,
  output pts_pkg::pts_cmd_t cmd
);
  import pts_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.div_sel = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.synced_mode) begin
          sel_nxt   = SEL_READING;
          state_nxt = ST_START;
        end else begin
          cmd.eval_ms = 1'b1;
          state_nxt   = ST_OUT;
        end
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.div_done) begin
          cmd.eval_div = 1'b1;
          if (sel_r == SEL_RESYNC) begin
            state_nxt = ST_OUT;
          end else begin
            sel_nxt   = sel_r + 2'd1;
            state_nxt = ST_START;
          end
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= SEL_READING;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

>>> src/periodic_trigger_scheduler_top.sv
// In millisecond modes a tick needs no division; synced mode takes three
// 32-bit remainders in turn from one restoring divider. One tick is in work
// at a time, so a new tick waits until the result of the last one is loaded;
// a stalled result holds off the next.
// Reset (rst_n low, synchronous) loads the default registers, clears all last
// firing times and empties the result register.
// ----------------------------------------------------------------------------
// periodic_trigger_scheduler_top
// Raises connect, time sync, reading and dispatch triggers for each tick.
// ----------------------------------------------------------------------------
module periodic_trigger_scheduler_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pts_pkg::pts_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pts_pkg::pts_out_t           out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pts_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [pts_pkg::DataW-1:0]   cfg_data
);
  import pts_pkg::*;

  pts_cmd_t cmd;
  pts_sts_t sts;

  assign cfg_ready = 1'b1;

  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
